>>> design/dzre_pkg.sv
// Shared types, constants and register codes of the dead-zone repeat event unit.
`default_nettype none

package dzre_pkg;

    // Default structural parameters.
    localparam int NUM_AXES_DEFAULT  = 6;
    localparam int AXIS_BITS_DEFAULT = 16;

    // Fixed field widths.
    localparam int PERIOD_BITS   = 16;
    localparam int DZ_BITS       = 15;
    localparam int INTERVAL_BITS = 16;
    localparam int COUNT_BITS    = 16;
    localparam int OUT_AXES      = 6;
    localparam int M_TDATA_W     = 16;

    // Accumulator and magnitude widths.
    localparam int ACC_BITS = 18;
    localparam int MAG_BITS = 17;
    localparam int STEP_W   = 5;
    localparam logic [MAG_BITS-1:0] ACC_LIMIT = 17'h1FFFF;

    // Substitutes for zero register values.
    localparam logic [DZ_BITS-1:0]    DEAD_ZONE_DEFAULT = 15'd16;
    localparam logic [COUNT_BITS-1:0] COUNT_DEFAULT     = 16'd4;

    // Configuration port.
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam logic [CFG_IDX_BITS-1:0] REG_DEAD_ZONE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_INTERVAL  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_COUNT     = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic eval;
        logic div_step;
        logic write_back;
        logic out_load;
    } dzre_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_busy;
    } dzre_status_t;

endpackage

`default_nettype wire

>>> design/axis_deadzone_repeat_events_unit.sv
// Top level of the dead-zone repeat event unit.
//
// One input beat on s_* carries a motion sample: NUM_AXES signed axis values and the
// period it covers. Each sample produces exactly one output beat on m_* with a
// positive-fire and a negative-fire flag per axis.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wdata while the block is idle:
// index 0 dead zone, 1 repeat interval in ms (zero selects count mode), 2 repeat count.
// Each axis runs through the shared bit-serial remainder unit, one dividend bit per cycle;
// the axes go one after another through evaluation, the remainder steps and write-back,
// and the result then waits for the output register. s_tready is high only while no
// sample is in progress.
// The output register holds a finished result; a new sample is accepted while that result
// still waits, and the next result waits in the controller until the register is free,
// with s_tready low meanwhile.
// Reset (aresetn low, synchronous) clears the accumulators, restores the register
// defaults and drops m_tvalid.
`default_nettype none

module axis_deadzone_repeat_events_unit #(
    parameter int NUM_AXES  = dzre_pkg::NUM_AXES_DEFAULT,
    parameter int AXIS_BITS = dzre_pkg::AXIS_BITS_DEFAULT,
    parameter int S_TDATA_W = ((NUM_AXES * AXIS_BITS + dzre_pkg::PERIOD_BITS + 7) / 8) * 8
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [dzre_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [dzre_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // Fields from bit 0 up: trans_x, trans_y, trans_z, rot_pitch, rot_roll, rot_yaw
    // (AXIS_BITS each, NUM_AXES of them), period_ms (16), zero fill.
    input  wire logic [S_TDATA_W-1:0]              s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // Fields from bit 0 up: pos_fired (6), neg_fired (6), zero fill (4).
    output logic [dzre_pkg::M_TDATA_W-1:0]          m_tdata
);
    import dzre_pkg::*;

    localparam int IDX_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

    dzre_cmd_t        cmd;
    dzre_status_t     status;
    logic [IDX_W-1:0] axis_idx;

    dzre_ctrl #(
        .NUM_AXES (NUM_AXES),
        .IDX_W    (IDX_W)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd),
        .axis_idx (axis_idx)
    );

    dzre_datapath #(
        .NUM_AXES  (NUM_AXES),
        .AXIS_BITS (AXIS_BITS),
        .IDX_W     (IDX_W),
        .S_TDATA_W (S_TDATA_W)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .axis_idx  (axis_idx),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

>>> design/dzre_rem.sv
// Bit-serial restoring remainder unit, one dividend bit per step.
`default_nettype none

module dzre_rem (
    input  wire logic                              aclk,
    input  wire logic                              start,
    input  wire logic                              step,
    input  wire logic [dzre_pkg::MAG_BITS-1:0]      dividend,
    input  wire logic [dzre_pkg::INTERVAL_BITS-1:0] divisor,
    output logic      [dzre_pkg::INTERVAL_BITS-1:0] remainder
);
    import dzre_pkg::*;

    logic [MAG_BITS-1:0]      shift_reg, shift_next;
    logic [INTERVAL_BITS-1:0] div_reg, div_next;
    logic [INTERVAL_BITS-1:0] rem_reg, rem_next;
    logic [INTERVAL_BITS+1:0] trial;

    // One trial subtraction of the divisor from the shifted partial remainder.
    always_comb begin
        trial      = {1'b0, rem_reg, shift_reg[MAG_BITS-1]} - {2'b00, div_reg};
        shift_next = shift_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        if (start) begin
            shift_next = dividend;
            div_next   = divisor;
            rem_next   = '0;
        end else if (step) begin
            shift_next = {shift_reg[MAG_BITS-2:0], 1'b0};
            if (trial[INTERVAL_BITS+1]) begin
                rem_next = {rem_reg[INTERVAL_BITS-2:0], shift_reg[MAG_BITS-1]};
            end else begin
                rem_next = trial[INTERVAL_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        div_reg   <= div_next;
        rem_reg   <= rem_next;
    end

    assign remainder = rem_reg;

endmodule

`default_nettype wire

>>> design/dzre_datapath.sv
// Datapath: configuration, sample and accumulator registers, remainder unit, result register.
`default_nettype none

module dzre_datapath #(
    parameter int NUM_AXES  = dzre_pkg::NUM_AXES_DEFAULT,
    parameter int AXIS_BITS = dzre_pkg::AXIS_BITS_DEFAULT,
    parameter int IDX_W     = 3,
    parameter int S_TDATA_W = 112
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [dzre_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [dzre_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    input  wire logic [S_TDATA_W-1:0]               s_tdata,
    input  wire dzre_pkg::dzre_cmd_t                cmd,
    input  wire logic [IDX_W-1:0]                   axis_idx,
    output dzre_pkg::dzre_status_t                  status,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [dzre_pkg::M_TDATA_W-1:0]          m_tdata
);
    import dzre_pkg::*;

    localparam int CMP_W = ((AXIS_BITS > DZ_BITS + 1) ? AXIS_BITS : DZ_BITS + 1) + 1;

    // Configuration registers.
    logic [DZ_BITS-1:0]       dead_zone_reg;
    logic [INTERVAL_BITS-1:0] interval_reg;
    logic [COUNT_BITS-1:0]    count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dead_zone_reg <= DEAD_ZONE_DEFAULT;
            interval_reg  <= '0;
            count_reg     <= COUNT_DEFAULT;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DEAD_ZONE: dead_zone_reg <= cfg_wdata[DZ_BITS-1:0];
                REG_INTERVAL:  interval_reg  <= cfg_wdata[INTERVAL_BITS-1:0];
                REG_COUNT:     count_reg     <= cfg_wdata[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    logic [DZ_BITS-1:0]    dz_eff;
    logic [COUNT_BITS-1:0] cnt_eff;
    logic                  time_mode;

    assign dz_eff    = (dead_zone_reg == '0) ? DEAD_ZONE_DEFAULT : dead_zone_reg;
    assign cnt_eff   = (count_reg == '0) ? COUNT_DEFAULT : count_reg;
    assign time_mode = (interval_reg != '0);

    // Captured sample beat.
    logic [AXIS_BITS-1:0]   axis_val_reg [NUM_AXES];
    logic [PERIOD_BITS-1:0] period_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                axis_val_reg[i] <= s_tdata[i*AXIS_BITS +: AXIS_BITS];
            end
            period_reg <= s_tdata[NUM_AXES*AXIS_BITS +: PERIOD_BITS];
        end
    end

    // Evaluation of the selected axis: direction and grown magnitude.
    logic [AXIS_BITS-1:0]     cur_val;
    logic signed [ACC_BITS-1:0] cur_acc;
    logic signed [CMP_W-1:0]  val_ext;
    logic signed [CMP_W-1:0]  dz_ext;
    logic                     go_pos;
    logic                     go_neg;
    logic [ACC_BITS-1:0]      acc_abs;
    logic [PERIOD_BITS-1:0]   incr;
    logic [MAG_BITS:0]        mag_sum;
    logic [MAG_BITS-1:0]      mag_sat;
    logic [INTERVAL_BITS-1:0] divisor;
    logic signed [ACC_BITS-1:0] accum_reg [NUM_AXES];

    always_comb begin
        cur_val = axis_val_reg[axis_idx];
        cur_acc = accum_reg[axis_idx];
        val_ext = $signed({{(CMP_W-AXIS_BITS){cur_val[AXIS_BITS-1]}}, cur_val});
        dz_ext  = $signed({{(CMP_W-DZ_BITS){1'b0}}, dz_eff});
        go_pos  = (val_ext > dz_ext) && !cur_acc[ACC_BITS-1];
        go_neg  = (val_ext < -dz_ext) && (cur_acc[ACC_BITS-1] || (cur_acc == '0));
        acc_abs = cur_acc[ACC_BITS-1] ? -cur_acc : cur_acc;
        incr    = time_mode ? period_reg : PERIOD_BITS'(1);
        mag_sum = {1'b0, acc_abs[MAG_BITS-1:0]}
                + {{(MAG_BITS+1-PERIOD_BITS){1'b0}}, incr};
        mag_sat = mag_sum[MAG_BITS] ? ACC_LIMIT : mag_sum[MAG_BITS-1:0];
        divisor = time_mode ? interval_reg : cnt_eff;
    end

    // Working registers of the axis in flight.
    logic                pos_dir_reg;
    logic                neg_dir_reg;
    logic [MAG_BITS-1:0] mag_reg;

    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            pos_dir_reg <= go_pos;
            neg_dir_reg <= go_neg;
            mag_reg     <= mag_sat;
        end
    end

    logic [INTERVAL_BITS-1:0] remainder;

    dzre_rem u_rem (
        .aclk      (aclk),
        .start     (cmd.eval),
        .step      (cmd.div_step),
        .dividend  (mag_sat),
        .divisor   (divisor),
        .remainder (remainder)
    );

    // Write-back: fire decision and new accumulator value.
    logic                     fire;
    logic [MAG_BITS-1:0]      new_mag;
    logic signed [ACC_BITS-1:0] new_acc;

    always_comb begin
        if (time_mode) begin
            fire = (mag_reg > {1'b0, interval_reg});
        end else begin
            fire = (remainder == '0);
        end
        if (!fire) begin
            new_mag = mag_reg;
        end else if (time_mode) begin
            new_mag = {1'b0, remainder};
        end else begin
            new_mag = {1'b0, cnt_eff};
        end
        if (pos_dir_reg) begin
            new_acc = $signed({1'b0, new_mag});
        end else if (neg_dir_reg) begin
            new_acc = -$signed({1'b0, new_mag});
        end else begin
            new_acc = '0;
        end
    end

    logic [NUM_AXES-1:0] pos_bits_reg;
    logic [NUM_AXES-1:0] neg_bits_reg;

    // Accumulators clear at reset; one axis is written per write-back.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                accum_reg[i] <= '0;
            end
        end else if (cmd.write_back) begin
            accum_reg[axis_idx] <= new_acc;
        end
    end

    // Fire flags of the current sample.
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            pos_bits_reg <= '0;
            neg_bits_reg <= '0;
        end else if (cmd.write_back) begin
            pos_bits_reg[axis_idx] <= pos_dir_reg && fire;
            neg_bits_reg[axis_idx] <= neg_dir_reg && fire;
        end
    end

    // Result fields, six bits each; missing axes read as zero.
    logic [OUT_AXES-1:0] pos_out;
    logic [OUT_AXES-1:0] neg_out;

    for (genvar g = 0; g < OUT_AXES; g++) begin : g_out
        if (g < NUM_AXES) begin : g_used
            assign pos_out[g] = pos_bits_reg[g];
            assign neg_out[g] = neg_bits_reg[g];
        end else begin : g_unused
            assign pos_out[g] = 1'b0;
            assign neg_out[g] = 1'b0;
        end
    end

    // Output register.
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= {{(M_TDATA_W-2*OUT_AXES){1'b0}}, neg_out, pos_out};
        end
    end

    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = m_tdata_reg;
    assign status.out_busy = m_tvalid_reg && !m_tready;

endmodule

`default_nettype wire

>>> design/dzre_ctrl.sv
// Controller: sequences the axes of one sample through evaluation, remainder steps and write-back.
`default_nettype none

module dzre_ctrl #(
    parameter int NUM_AXES = dzre_pkg::NUM_AXES_DEFAULT,
    parameter int IDX_W    = 3
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire dzre_pkg::dzre_status_t status,
    output dzre_pkg::dzre_cmd_t         cmd,
    output logic [IDX_W-1:0]            axis_idx
);
    import dzre_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_EVAL = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_WB   = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

    localparam logic [IDX_W-1:0]  LAST_AXIS = IDX_W'(NUM_AXES - 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAG_BITS - 1);

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [STEP_W-1:0] step_reg, step_next;

    // Next-state and command decode.
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    idx_next    = '0;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval   = 1'b1;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (step_reg == LAST_STEP) begin
                    state_next = ST_WB;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_WB: begin
                cmd.write_back = 1'b1;
                if (idx_reg == LAST_AXIS) begin
                    state_next = ST_FIN;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_FIN: begin
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
        end
    end

    assign axis_idx = idx_reg;

endmodule

`default_nettype wire

>>> design/dzre_checker.sv
// Port-level checker of the dead-zone repeat event unit and its bind.
`default_nettype none

module dzre_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [dzre_pkg::M_TDATA_W-1:0] m_tdata
);
    import dzre_pkg::*;

    // A stalled result beat stays put.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Reset drops the output beat.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // An axis never fires both directions in one sample.
    a_one_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OUT_AXES-1:0] & m_tdata[2*OUT_AXES-1:OUT_AXES]) == '0)
        else $error("axis fired both directions");

    // Fill bits stay zero.
    a_fill_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:2*OUT_AXES] == '0)
        else $error("nonzero fill bits in result beat");

    // A result never appears in the cycle right after a sample is taken.
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared one cycle after acceptance");

endmodule

bind axis_deadzone_repeat_events_unit dzre_checker u_dzre_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

>>> verif/dzre_fire_checker.sv
// Checker that predicts the fire flags of the dead-zone repeat event unit and compares them.
module dzre_fire_checker import dzre_pkg::*; #(
    parameter int NUM_AXES  = NUM_AXES_DEFAULT,
    parameter int AXIS_BITS = AXIS_BITS_DEFAULT,
    parameter int S_TDATA_W = ((NUM_AXES * AXIS_BITS + PERIOD_BITS + 7) / 8) * 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    // Fields from bit 0 up: trans_x, trans_y, trans_z, rot_pitch, rot_roll, rot_yaw,
    // period_ms, zero fill.
    input  logic [S_TDATA_W-1:0]     s_tdata,
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    // Fields from bit 0 up: pos_fired (6), neg_fired (6), zero fill (4).
    input  logic [M_TDATA_W-1:0]     m_tdata,
    output int                       errors,
    output int                       pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // One result beat: positive flags in the low bits, negative flags above them.
    typedef struct packed {
        logic [OUT_AXES-1:0] neg_fired;
        logic [OUT_AXES-1:0] pos_fired;
    } fire_flags_t;

    // Shadow of the block's registers and per-axis charge.
    logic signed [ACC_BITS-1:0] axis_charge [NUM_AXES];
    logic [DZ_BITS-1:0]         dead_zone_r;
    logic [INTERVAL_BITS-1:0]   interval_r;
    logic [COUNT_BITS-1:0]      count_r;
    fire_flags_t                expected_fires_q[$];
    int                         mismatches = 0;

    // Charge every axis with one motion sample and return the directions that fire.
    function automatic fire_flags_t charge_axes(input logic [S_TDATA_W-1:0] beat);
        fire_flags_t flags;
        int          threshold;
        int          every;
        int          period;
        int          level;
        int          charge;
        int          mag;
        int          heading;
        bit          fired;
        flags     = '0;
        threshold = (dead_zone_r == '0) ? int'(DEAD_ZONE_DEFAULT) : int'(dead_zone_r);
        every     = (count_r == '0) ? int'(COUNT_DEFAULT) : int'(count_r);
        period    = int'(beat[NUM_AXES*AXIS_BITS +: PERIOD_BITS]);
        for (int i = 0; i < NUM_AXES; i++) begin
            level   = int'($signed(beat[i*AXIS_BITS +: AXIS_BITS]));
            charge  = int'(axis_charge[i]);
            heading = 0;
            fired   = 1'b0;
            if (level > threshold && charge >= 0) begin
                heading = 1;
            end else if (level < -threshold && charge <= 0) begin
                heading = -1;
            end
            if (heading == 0) begin
                // Inside the dead zone or reversing: the charge is dropped.
                axis_charge[i] = '0;
            end else begin
                mag = (charge < 0) ? -charge : charge;
                if (interval_r != '0) begin
                    // Time mode: add the period, fire and keep the remainder past the interval.
                    mag = mag + period;
                    if (mag > int'(ACC_LIMIT)) mag = int'(ACC_LIMIT);
                    if (mag > int'(interval_r)) begin
                        mag   = mag % int'(interval_r);
                        fired = 1'b1;
                    end
                end else begin
                    // Count mode: one step per sample, fire on each multiple of the count.
                    mag = mag + 1;
                    if (mag > int'(ACC_LIMIT)) mag = int'(ACC_LIMIT);
                    if (mag % every == 0) begin
                        mag   = every;
                        fired = 1'b1;
                    end
                end
                axis_charge[i] = (heading > 0) ? ACC_BITS'(mag) : ACC_BITS'(-mag);
                if (fired && i < OUT_AXES) begin
                    if (heading > 0) begin
                        flags.pos_fired[i] = 1'b1;
                    end else begin
                        flags.neg_fired[i] = 1'b1;
                    end
                end
            end
        end
        return flags;
    endfunction

    // Track register writes, predict on each sample beat, compare each result beat.
    always @(posedge aclk) begin
        fire_flags_t seen;
        fire_flags_t want;
        if (!aresetn) begin
            expected_fires_q.delete();
            dead_zone_r = DEAD_ZONE_DEFAULT;
            interval_r  = '0;
            count_r     = COUNT_DEFAULT;
            foreach (axis_charge[i]) axis_charge[i] = '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_DEAD_ZONE: dead_zone_r = cfg_wdata[DZ_BITS-1:0];
                    REG_INTERVAL:  interval_r  = cfg_wdata[INTERVAL_BITS-1:0];
                    REG_COUNT:     count_r     = cfg_wdata[COUNT_BITS-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                seen = m_tdata[2*OUT_AXES-1:0];
                if (expected_fires_q.size() == 0) begin
                    $error("result beat with no sample outstanding: m_tdata %0h", m_tdata);
                    mismatches++;
                end else begin
                    want = expected_fires_q.pop_front();
                    if (seen.pos_fired !== want.pos_fired) begin
                        $error("pos_fired: expected %b, actual %b", want.pos_fired,
                               seen.pos_fired);
                        mismatches++;
                    end
                    if (seen.neg_fired !== want.neg_fired) begin
                        $error("neg_fired: expected %b, actual %b", want.neg_fired,
                               seen.neg_fired);
                        mismatches++;
                    end
                end
                if (m_tdata[M_TDATA_W-1:2*OUT_AXES] !== '0) begin
                    $error("zero fill: expected 0, actual %b", m_tdata[M_TDATA_W-1:2*OUT_AXES]);
                    mismatches++;
                end
            end
            if (s_tvalid && s_tready) begin
                expected_fires_q.push_back(charge_axes(s_tdata));
            end
        end
        errors  <= mismatches;
        pending <= expected_fires_q.size();
    end

endmodule

>>> verif/axis_deadzone_repeat_events_unit_test.sv
// Testbench top: clock, reset, stimulus and verdict for the dead-zone repeat event unit.
module axis_deadzone_repeat_events_unit_test import dzre_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_AXES         = 6;
    localparam int AXIS_BITS        = 16;
    localparam int S_W              = ((NUM_AXES * AXIS_BITS + PERIOD_BITS + 7) / 8) * 8;
    localparam int PHASES           = 8;
    localparam int RANDOM_PER_PHASE = 190;
    localparam int HOLD_CYCLES      = 1500;
    localparam int STALL_LIMIT      = 6000;
    localparam int DRAIN_CYCLES     = 130;

    // One motion sample, laid out as on s_tdata: axes from bit 0 up, period on top.
    typedef struct packed {
        logic [PERIOD_BITS-1:0]              period;
        logic [NUM_AXES-1:0][AXIS_BITS-1:0] axis;
    } motion_t;

    // How an axis is steered over a run of samples.
    typedef enum int {PUSH_POS, PUSH_NEG, NEAR_EDGE, ANY_VALUE, AT_REST} axis_drive_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_wr_en;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_wdata;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [S_W-1:0]           s_tdata;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [M_TDATA_W-1:0]     m_tdata;
    int                       errors;
    int                       pending;
    int                       stall_cycles = 0;
    int                       thr_now = 16;
    int                       interval_now = 0;
    bit                       quiet = 1'b0;
    bit                       hold_req = 1'b0;
    axis_drive_t              drive [NUM_AXES];

    // Register settings of the random phases: dead zone, interval, count.
    logic [15:0] dz_tab  [PHASES] = '{16'h0000, 16'hFFFF, 16'd1000, 16'd200,
                                      16'd5, 16'd300, 16'd16, 16'd40};
    logic [15:0] iv_tab  [PHASES] = '{16'd0, 16'd100, 16'd1, 16'hFFFF,
                                      16'd0, 16'd37, 16'd0, 16'd12};
    logic [15:0] cnt_tab [PHASES] = '{16'd0, 16'd1, 16'hFFFF, 16'd7,
                                      16'd1, 16'd3, 16'hFFFF, 16'd2};

    axis_deadzone_repeat_events_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    dzre_fire_checker fire_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .errors    (errors),
        .pending   (pending)
    );

    // Clock.
    initial aclk = 1'b0;
    always #10ns aclk = ~aclk;

    // Watchdog: end the run when no beat or register write happens for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("axis_deadzone_repeat_events_unit test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Result side: random back-pressure bursts, plus one long hold-off on request.
    initial begin
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    end

    // Offer one sample beat, with an occasional gap in front, and wait until it is taken.
    task automatic send_motion(input motion_t smp);
        if (!quiet && $urandom_range(0, 2) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Stop offering and wait until every sample has produced its result.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write all three registers once the block is idle.
    task automatic configure(input logic [15:0] dz, input logic [15:0] iv,
                             input logic [15:0] cnt);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_DEAD_ZONE;
        cfg_wdata <= dz;
        @(posedge aclk);
        cfg_index <= REG_INTERVAL;
        cfg_wdata <= iv;
        @(posedge aclk);
        cfg_index <= REG_COUNT;
        cfg_wdata <= cnt;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        thr_now      = (dz[14:0] == '0) ? 16 : int'(dz[14:0]);
        interval_now = int'(iv);
    endtask

    // A sample with the same value on every axis.
    function automatic motion_t level_motion(input int v, input int p);
        motion_t smp;
        smp.period = p[15:0];
        for (int a = 0; a < NUM_AXES; a++) smp.axis[a] = v[15:0];
        return smp;
    endfunction

    // Stimulus and verdict.
    initial begin
        motion_t smp;
        int      v;
        int      p;
        int      span;
        int      pick;
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_DEAD_ZONE;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        for (int a = 0; a < NUM_AXES; a++) drive[a] = ANY_VALUE;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings, count mode: extremes, the threshold edge and a sign reversal.
        smp.period  = 16'd0;
        smp.axis[0] = 16'h0000;
        smp.axis[1] = 16'h7FFF;
        smp.axis[2] = 16'h8000;
        smp.axis[3] = 16'd16;
        smp.axis[4] = 16'hFFF0;
        smp.axis[5] = 16'd17;
        send_motion(smp);
        repeat (4) send_motion(level_motion(32767, 65535));
        repeat (5) send_motion(level_motion(-32768, 0));
        send_motion(level_motion(17, 1));
        send_motion(level_motion(-17, 1));
        send_motion(level_motion(16, 1));
        send_motion(level_motion(-16, 1));

        // Zero dead zone and zero count fall back to their defaults.
        configure(16'h0000, 16'h0000, 16'h0000);
        repeat (4) send_motion(level_motion(17, 3));
        send_motion(level_motion(16, 3));

        // Time mode: negative remainder kept, exact interval not firing, zero remainder.
        configure(16'd100, 16'd10, 16'd0);
        repeat (2) send_motion(level_motion(-500, 7));
        send_motion(level_motion(-500, 6));
        send_motion(level_motion(-500, 10));
        send_motion(level_motion(500, 65535));

        // Random phases: axes mostly held in one direction for runs of samples.
        for (int ph = 0; ph < PHASES; ph++) begin
            configure(dz_tab[ph], iv_tab[ph], cnt_tab[ph]);
            quiet = (ph == PHASES - 1);
            if (ph == 2) hold_req = 1'b1;
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        pick = $urandom_range(0, 9);
                        if (pick < 4)       drive[a] = PUSH_POS;
                        else if (pick < 7)  drive[a] = PUSH_NEG;
                        else if (pick == 7) drive[a] = NEAR_EDGE;
                        else if (pick == 8) drive[a] = ANY_VALUE;
                        else                drive[a] = AT_REST;
                    end
                    unique case (drive[a])
                        PUSH_POS: begin
                            v = (thr_now >= 32767) ? 32767
                                                   : int'($urandom_range(32767, thr_now + 1));
                        end
                        PUSH_NEG: begin
                            v = -int'($urandom_range(32768, thr_now + 1));
                        end
                        NEAR_EDGE: begin
                            v = thr_now - 2 + int'($urandom_range(0, 4));
                            if ($urandom_range(0, 1) == 1) v = -v;
                        end
                        ANY_VALUE: begin
                            v = int'($urandom());
                        end
                        default: begin
                            v = int'($urandom_range(0, 8)) - 4;
                        end
                    endcase
                    smp.axis[a] = v[15:0];
                end
                // Periods mostly on the scale of the interval, sometimes anything.
                if (interval_now == 0 || $urandom_range(0, 4) == 0) begin
                    p = int'($urandom());
                end else begin
                    span = 2 * interval_now;
                    if (span > 65535) span = 65535;
                    p = int'($urandom_range(0, span));
                end
                smp.period = p[15:0];
                send_motion(smp);
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending != 0) $error("%0d expected results never arrived", pending);
        if (errors == 0 && pending == 0) begin
            $display("axis_deadzone_repeat_events_unit test passed");
        end else begin
            $display("axis_deadzone_repeat_events_unit test failed");
        end
        $finish;
    end

endmodule
